>>> rtl/periodic_task_timer_table_defines.svh
// assertion macros for the periodic task timer table
`ifndef PERIODIC_TASK_TIMER_TABLE_DEFINES_SVH
`define PERIODIC_TASK_TIMER_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define PTT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptt assertion failed");
`define PTT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptt assertion failed");
`else
`define PTT_ASSERT_SAME(label, ante, cons)
`define PTT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/ptt_pkg.sv
// types, codes and constants of the periodic task timer table
package ptt_pkg;

  localparam int NUM_SLOTS_DEF  = 8;
  localparam int MAX_RESULTS    = 8;
  localparam int MS_PER_S       = 1000;
  localparam int PERIOD_S_W     = 16;
  localparam int SLOT_OUT_W     = 3;
  localparam int MIN_PERIOD_RST = 1;

  typedef logic [15:0] id_t;
  typedef logic [15:0] period_s_t;
  typedef logic [25:0] period_ms_t;
  typedef logic [31:0] time_ms_t;
  typedef logic [7:0]  step_t;
  typedef logic [SLOT_OUT_W-1:0] slot_out_t;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_ENABLE  = 2'd1,
    OP_DISABLE = 2'd2,
    OP_TICK    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_ACK   = 2'd1,
    KIND_FIRED = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_ADDW,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    id_t        task_id;
    period_ms_t period_ms;
    time_ms_t   deadline;
  } slot_word_t;

endpackage

>>> rtl/ptt_ram.sv
// generic single-port-write ram with registered read
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/periodic_task_timer_table.sv
// Periodic task timer table. Commands are taken when start is high and busy is low; every
// result word shows for one cycle with out_valid and cannot be held off. Task id, period
// and deadline of each slot live in one ram read back and rewritten one slot per cycle.
// Per command: disable-all and a refused add (table full) are answered straight from idle;
// an accepted add runs the one-bit-per-cycle remainder unit that rounds the 16-bit period,
// then the millisecond multiply and the ram write; enable-all and tick run the ram scan
// of one slot per cycle. A tick gives up to 8 fired words, lowest slot first, or one
// nothing-fired word; out_last marks the final word of each command. No clearing pass
// is needed after reset.
`include "periodic_task_timer_table_defines.svh"

module periodic_task_timer_table #(
  parameter int NUM_SLOTS = ptt_pkg::NUM_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_operation,
  input  logic [15:0]           in_task_id,
  input  logic [15:0]           in_period_s,
  input  logic [31:0]           in_now_ms,
  output logic                  out_valid,
  output logic [1:0]            out_kind,
  output logic                  out_accepted,
  output logic [15:0]           out_fired_id,
  output logic [2:0]            out_slot,
  output logic                  out_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_min_period_s
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(ptt_pkg::PERIOD_S_W);
  localparam int N_W   = $clog2(ptt_pkg::MAX_RESULTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ptt_pkg::PERIOD_S_W - 1);
  localparam logic [N_W-1:0]   N_MAX    = N_W'(ptt_pkg::MAX_RESULTS);

  // control state
  ptt_pkg::state_t  state_r, state_nxt;
  ptt_pkg::op_t     op_r, op_nxt;
  logic [NUM_SLOTS-1:0] used_r, used_nxt;
  logic [NUM_SLOTS-1:0] armed_r, armed_nxt;
  ptt_pkg::step_t   min_r, min_nxt;
  logic [IDX_W-1:0] addr_r, addr_nxt;
  logic             issue_r, issue_nxt;
  logic             p_vld_r, p_vld_nxt;
  logic [IDX_W-1:0] p_idx_r, p_idx_nxt;
  logic [N_W-1:0]   n_r, n_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload
  ptt_pkg::id_t       pend_id_r, pend_id_nxt;
  ptt_pkg::slot_out_t pend_slot_r, pend_slot_nxt;
  ptt_pkg::id_t       id_r, id_nxt;
  ptt_pkg::period_s_t per_r, per_nxt;
  ptt_pkg::period_s_t dvd_r, dvd_nxt;
  ptt_pkg::step_t     rem_r, rem_nxt;
  ptt_pkg::period_ms_t per_ms_r, per_ms_nxt;
  logic [IDX_W-1:0]   free_r, free_nxt;
  ptt_pkg::time_ms_t  now_r, now_nxt;
  ptt_pkg::kind_t     out_kind_r, out_kind_nxt;
  logic               out_accepted_r, out_accepted_nxt;
  ptt_pkg::id_t       out_fired_id_r, out_fired_id_nxt;
  ptt_pkg::slot_out_t out_slot_r, out_slot_nxt;
  logic               out_last_r, out_last_nxt;

  // ram port
  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  ptt_pkg::slot_word_t ram_wdata, ram_rdata;

  // helpers
  ptt_pkg::step_t     step_c;
  ptt_pkg::period_s_t per_c;
  logic [IDX_W-1:0]   free_c;
  logic               full_c;
  logic [8:0]         rem_sh;
  ptt_pkg::period_s_t per_round;
  logic               due_c;
  ptt_pkg::time_ms_t  reload_c;

  ptt_ram #(
    .WIDTH ($bits(ptt_pkg::slot_word_t)),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // zero minimum acts as one
  assign step_c = (min_r == '0) ? ptt_pkg::step_t'(1) : min_r;
  assign per_c  = (in_period_s < {8'd0, step_c}) ? {8'd0, step_c} : in_period_s;

  always_comb begin
    free_c = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_c = IDX_W'(i);
      end
    end
  end
  assign full_c = &used_r;

  assign rem_sh    = {rem_r, dvd_r[ptt_pkg::PERIOD_S_W-1]};
  assign per_round = per_r - {8'd0, rem_r};
  assign reload_c  = now_r + {6'd0, ram_rdata.period_ms};
  assign due_c     = used_r[p_idx_r] && armed_r[p_idx_r] &&
                     (now_r >= ram_rdata.deadline) && (n_r != N_MAX);

  always_comb begin
    state_nxt        = state_r;
    op_nxt           = op_r;
    used_nxt         = used_r;
    armed_nxt        = armed_r;
    min_nxt          = min_r;
    addr_nxt         = addr_r;
    issue_nxt        = issue_r;
    p_vld_nxt        = 1'b0;
    p_idx_nxt        = p_idx_r;
    n_nxt            = n_r;
    pend_vld_nxt     = pend_vld_r;
    pend_id_nxt      = pend_id_r;
    pend_slot_nxt    = pend_slot_r;
    cnt_nxt          = cnt_r;
    id_nxt           = id_r;
    per_nxt          = per_r;
    dvd_nxt          = dvd_r;
    rem_nxt          = rem_r;
    per_ms_nxt       = per_ms_r;
    free_nxt         = free_r;
    now_nxt          = now_r;
    out_valid_nxt    = 1'b0;
    out_kind_nxt     = out_kind_r;
    out_accepted_nxt = out_accepted_r;
    out_fired_id_nxt = out_fired_id_r;
    out_slot_nxt     = out_slot_r;
    out_last_nxt     = out_last_r;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    ram_waddr        = p_idx_r;
    ram_raddr        = addr_r;
    ram_wdata        = '0;

    if (cfg_valid) begin
      min_nxt = cfg_min_period_s;
    end

    unique case (state_r)
      ptt_pkg::ST_IDLE: begin
        if (start) begin
          op_nxt = ptt_pkg::op_t'(in_operation);
          now_nxt = in_now_ms;
          unique case (ptt_pkg::op_t'(in_operation))
            ptt_pkg::OP_ADD: begin
              if (full_c) begin
                out_valid_nxt    = 1'b1;
                out_kind_nxt     = ptt_pkg::KIND_ADD;
                out_accepted_nxt = 1'b0;
                out_fired_id_nxt = in_task_id;
                out_slot_nxt     = '0;
                out_last_nxt     = 1'b1;
              end else begin
                id_nxt    = in_task_id;
                per_nxt   = per_c;
                dvd_nxt   = per_c;
                rem_nxt   = '0;
                cnt_nxt   = '0;
                free_nxt  = free_c;
                state_nxt = ptt_pkg::ST_DIV;
              end
            end
            ptt_pkg::OP_DISABLE: begin
              armed_nxt        = '0;
              out_valid_nxt    = 1'b1;
              out_kind_nxt     = ptt_pkg::KIND_ACK;
              out_accepted_nxt = 1'b0;
              out_fired_id_nxt = '0;
              out_slot_nxt     = '0;
              out_last_nxt     = 1'b1;
            end
            ptt_pkg::OP_ENABLE, ptt_pkg::OP_TICK: begin
              if (ptt_pkg::op_t'(in_operation) == ptt_pkg::OP_ENABLE) begin
                armed_nxt = used_r;
              end
              addr_nxt     = '0;
              issue_nxt    = 1'b1;
              n_nxt        = '0;
              pend_vld_nxt = 1'b0;
              state_nxt    = ptt_pkg::ST_SCAN;
            end
            default: ;
          endcase
        end
      end

      // remainder of period by step, one dividend bit per cycle
      ptt_pkg::ST_DIV: begin
        if (rem_sh >= {1'b0, step_c}) begin
          rem_nxt = ptt_pkg::step_t'(rem_sh - {1'b0, step_c});
        end else begin
          rem_nxt = ptt_pkg::step_t'(rem_sh);
        end
        dvd_nxt = dvd_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = ptt_pkg::ST_MUL;
        end
      end

      ptt_pkg::ST_MUL: begin
        per_ms_nxt = ptt_pkg::period_ms_t'({10'd0, per_round} *
                                           ptt_pkg::period_ms_t'(ptt_pkg::MS_PER_S));
        state_nxt  = ptt_pkg::ST_ADDW;
      end

      ptt_pkg::ST_ADDW: begin
        ram_we              = 1'b1;
        ram_waddr           = free_r;
        ram_wdata.task_id   = id_r;
        ram_wdata.period_ms = per_ms_r;
        ram_wdata.deadline  = '0;
        used_nxt[free_r]    = 1'b1;
        armed_nxt[free_r]   = 1'b0;
        out_valid_nxt       = 1'b1;
        out_kind_nxt        = ptt_pkg::KIND_ADD;
        out_accepted_nxt    = 1'b1;
        out_fired_id_nxt    = id_r;
        out_slot_nxt        = ptt_pkg::slot_out_t'(free_r);
        out_last_nxt        = 1'b1;
        state_nxt           = ptt_pkg::ST_IDLE;
      end

      // read slot addr_r while slot p_idx_r comes back and is rewritten
      ptt_pkg::ST_SCAN: begin
        if (issue_r) begin
          ram_re    = 1'b1;
          p_vld_nxt = 1'b1;
          p_idx_nxt = addr_r;
          if (addr_r == LAST_IDX) begin
            issue_nxt = 1'b0;
          end else begin
            addr_nxt = addr_r + 1'b1;
          end
        end
        if (p_vld_r) begin
          if (op_r == ptt_pkg::OP_ENABLE) begin
            if (used_r[p_idx_r]) begin
              ram_we             = 1'b1;
              ram_wdata          = ram_rdata;
              ram_wdata.deadline = reload_c;
            end
          end else if (due_c) begin
            ram_we             = 1'b1;
            ram_wdata          = ram_rdata;
            ram_wdata.deadline = reload_c;
            n_nxt              = n_r + 1'b1;
            // a newer hit proves the held one is not final
            if (pend_vld_r) begin
              out_valid_nxt    = 1'b1;
              out_kind_nxt     = ptt_pkg::KIND_FIRED;
              out_accepted_nxt = 1'b0;
              out_fired_id_nxt = pend_id_r;
              out_slot_nxt     = pend_slot_r;
              out_last_nxt     = 1'b0;
            end
            pend_vld_nxt  = 1'b1;
            pend_id_nxt   = ram_rdata.task_id;
            pend_slot_nxt = ptt_pkg::slot_out_t'(p_idx_r);
          end
          if (p_idx_r == LAST_IDX) begin
            state_nxt = ptt_pkg::ST_DONE;
          end
        end
      end

      ptt_pkg::ST_DONE: begin
        out_valid_nxt    = 1'b1;
        out_accepted_nxt = 1'b0;
        out_last_nxt     = 1'b1;
        if (op_r == ptt_pkg::OP_ENABLE) begin
          out_kind_nxt     = ptt_pkg::KIND_ACK;
          out_fired_id_nxt = '0;
          out_slot_nxt     = '0;
        end else if (pend_vld_r) begin
          out_kind_nxt     = ptt_pkg::KIND_FIRED;
          out_fired_id_nxt = pend_id_r;
          out_slot_nxt     = pend_slot_r;
        end else begin
          out_kind_nxt     = ptt_pkg::KIND_NONE;
          out_fired_id_nxt = '0;
          out_slot_nxt     = '0;
        end
        state_nxt = ptt_pkg::ST_IDLE;
      end

      default: state_nxt = ptt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptt_pkg::ST_IDLE;
      op_r        <= ptt_pkg::OP_ADD;
      used_r      <= '0;
      armed_r     <= '0;
      min_r       <= ptt_pkg::step_t'(ptt_pkg::MIN_PERIOD_RST);
      addr_r      <= '0;
      issue_r     <= 1'b0;
      p_vld_r     <= 1'b0;
      p_idx_r     <= '0;
      n_r         <= '0;
      pend_vld_r  <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      used_r      <= used_nxt;
      armed_r     <= armed_nxt;
      min_r       <= min_nxt;
      addr_r      <= addr_nxt;
      issue_r     <= issue_nxt;
      p_vld_r     <= p_vld_nxt;
      p_idx_r     <= p_idx_nxt;
      n_r         <= n_nxt;
      pend_vld_r  <= pend_vld_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_id_r      <= pend_id_nxt;
    pend_slot_r    <= pend_slot_nxt;
    id_r           <= id_nxt;
    per_r          <= per_nxt;
    dvd_r          <= dvd_nxt;
    rem_r          <= rem_nxt;
    per_ms_r       <= per_ms_nxt;
    free_r         <= free_nxt;
    now_r          <= now_nxt;
    out_kind_r     <= out_kind_nxt;
    out_accepted_r <= out_accepted_nxt;
    out_fired_id_r <= out_fired_id_nxt;
    out_slot_r     <= out_slot_nxt;
    out_last_r     <= out_last_nxt;
  end

  assign busy         = (state_r != ptt_pkg::ST_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_accepted = out_accepted_r;
  assign out_fired_id = out_fired_id_r;
  assign out_slot     = out_slot_r;
  assign out_last     = out_last_r;

  `PTT_ASSERT_SAME(a_armed_only_used, 1'b1, (armed_r & ~used_r) == '0)
  `PTT_ASSERT_SAME(a_fire_count, 1'b1, n_r <= N_MAX)
  `PTT_ASSERT_NEXT(a_done_gives_last, state_r == ptt_pkg::ST_DONE, out_valid_r && out_last_r)
  `PTT_ASSERT_SAME(a_ram_write_state, ram_we,
                   state_r == ptt_pkg::ST_SCAN || state_r == ptt_pkg::ST_ADDW)

endmodule

>>> verif/periodic_task_timer_table_tb.sv
// testbench for the periodic task timer table with a command scoreboard
module periodic_task_timer_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = ptt_pkg::NUM_SLOTS_DEF;
  localparam int WORDS_PER_PHASE = 62;
  localparam int SETTLE_CYCLES = 30;

  typedef struct packed {
    ptt_pkg::kind_t     kind;
    logic               accepted;
    ptt_pkg::id_t       fired_id;
    ptt_pkg::slot_out_t slot;
    logic               last;
  } result_word_t;

  class slot_table_tracker;
    logic [7:0]          min_period_s;
    bit                  used [SLOTS];
    bit                  armed [SLOTS];
    ptt_pkg::id_t        task_id [SLOTS];
    ptt_pkg::period_ms_t period_ms [SLOTS];
    ptt_pkg::time_ms_t   deadline [SLOTS];
    result_word_t        pending_words [$];
    int                  mismatches;
    int                  words_checked;
    int                  fired_words;
    int                  refused_adds;
    int                  commands;

    function new();
      min_period_s = 8'(ptt_pkg::MIN_PERIOD_RST);
      for (int i = 0; i < SLOTS; i++) begin
        used[i] = 1'b0;
        armed[i] = 1'b0;
        task_id[i] = '0;
        period_ms[i] = '0;
        deadline[i] = '0;
      end
      mismatches = 0;
      words_checked = 0;
      fired_words = 0;
      refused_adds = 0;
      commands = 0;
    endfunction

    function void take_command(ptt_pkg::op_t op, ptt_pkg::id_t id,
                               ptt_pkg::period_s_t per_s, ptt_pkg::time_ms_t now);
      logic [31:0]  step;
      logic [31:0]  per;
      int           free_slot;
      result_word_t w;
      result_word_t burst [$];
      commands++;
      w = '0;
      w.last = 1'b1;
      case (op)
        ptt_pkg::OP_ADD: begin
          // a zero minimum behaves as one second
          step = (min_period_s == 8'd0) ? 32'd1 : {24'd0, min_period_s};
          per = {16'd0, per_s};
          if (per < step) per = step;
          per = per - (per % step);
          free_slot = -1;
          for (int i = 0; i < SLOTS; i++)
            if (!used[i] && free_slot < 0) free_slot = i;
          w.kind = ptt_pkg::KIND_ADD;
          w.fired_id = id;
          if (free_slot >= 0) begin
            used[free_slot] = 1'b1;
            armed[free_slot] = 1'b0;
            task_id[free_slot] = id;
            period_ms[free_slot] = ptt_pkg::period_ms_t'(per * ptt_pkg::MS_PER_S);
            w.accepted = 1'b1;
            w.slot = ptt_pkg::slot_out_t'(free_slot);
          end else begin
            refused_adds++;
          end
          pending_words.push_back(w);
        end
        ptt_pkg::OP_ENABLE, ptt_pkg::OP_DISABLE: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (op == ptt_pkg::OP_DISABLE) begin
              armed[i] = 1'b0;
            end else if (used[i]) begin
              armed[i] = 1'b1;
              deadline[i] = now + ptt_pkg::time_ms_t'(period_ms[i]);
            end
          end
          w.kind = ptt_pkg::KIND_ACK;
          pending_words.push_back(w);
        end
        default: begin
          // tick: due slots fire lowest first and reload, deadline sum wraps at 32 bits
          for (int i = 0; i < SLOTS; i++) begin
            if (burst.size() < ptt_pkg::MAX_RESULTS && used[i] && armed[i] &&
                now >= deadline[i]) begin
              deadline[i] = now + ptt_pkg::time_ms_t'(period_ms[i]);
              w.kind = ptt_pkg::KIND_FIRED;
              w.fired_id = task_id[i];
              w.slot = ptt_pkg::slot_out_t'(i);
              w.last = 1'b0;
              burst.push_back(w);
            end
          end
          if (burst.size() == 0) begin
            w.kind = ptt_pkg::KIND_NONE;
            pending_words.push_back(w);
          end else begin
            fired_words += burst.size();
            w = burst.pop_back();
            w.last = 1'b1;
            burst.push_back(w);
            foreach (burst[k]) pending_words.push_back(burst[k]);
          end
        end
      endcase
    endfunction

    function void check_word(result_word_t got);
      result_word_t want;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected word kind %0d acc %0d id %h slot %0d last %0d",
                   $time, got.kind, got.accepted, got.fired_id, got.slot, got.last);
        return;
      end
      want = pending_words.pop_front();
      words_checked++;
      if (got.kind !== want.kind || got.accepted !== want.accepted ||
          got.fired_id !== want.fired_id || got.slot !== want.slot ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch, expected kind %0d acc %0d id %h slot %0d last %0d",
                   $time, want.kind, want.accepted, want.fired_id, want.slot, want.last);
          $display("%0t:           got kind %0d acc %0d id %h slot %0d last %0d",
                   $time, got.kind, got.accepted, got.fired_id, got.slot, got.last);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_operation = '0;
  logic [15:0] in_task_id = '0;
  logic [15:0] in_period_s = '0;
  logic [31:0] in_now_ms = '0;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic        out_accepted;
  logic [15:0] out_fired_id;
  logic [2:0]  out_slot;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_min_period_s = '0;

  slot_table_tracker tracker = new();
  result_word_t      seen_word;
  int                sender_idle_pct = 14;
  ptt_pkg::time_ms_t clock_ms = '0;

  periodic_task_timer_table dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_task_id       (in_task_id),
    .in_period_s      (in_period_s),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_accepted     (out_accepted),
    .out_fired_id     (out_fired_id),
    .out_slot         (out_slot),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_min_period_s (cfg_min_period_s)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tracker.min_period_s = cfg_min_period_s;
      if (start && !busy)
        tracker.take_command(ptt_pkg::op_t'(in_operation), in_task_id, in_period_s,
                             in_now_ms);
      if (out_valid) begin
        seen_word.kind = ptt_pkg::kind_t'(out_kind);
        seen_word.accepted = out_accepted;
        seen_word.fired_id = out_fired_id;
        seen_word.slot = out_slot;
        seen_word.last = out_last;
        tracker.check_word(seen_word);
      end
    end
  end

  task automatic issue_command(ptt_pkg::op_t op, ptt_pkg::id_t id,
                               ptt_pkg::period_s_t per_s, ptt_pkg::time_ms_t now);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_task_id <= id;
    in_period_s <= per_s;
    in_now_ms <= now;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_min_period(logic [7:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending_words.size() != 0) @(posedge clk);
    // all words drained, so the block is idle; a short margin before the write
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_min_period_s <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_command();
    int                pick;
    ptt_pkg::time_ms_t advance;
    pick = $urandom_range(99);
    if (pick < 50) begin
      // mostly short steps of time, now and then a jump that can pass the longest periods
      advance = ($urandom_range(3) == 0) ? $urandom_range(70_000_000)
                                         : $urandom_range(600_000);
      clock_ms = clock_ms + advance;
      issue_command(ptt_pkg::OP_TICK, ptt_pkg::id_t'($urandom),
                    ptt_pkg::period_s_t'($urandom), clock_ms);
    end else if (pick < 62) begin
      issue_command(ptt_pkg::OP_ENABLE, ptt_pkg::id_t'($urandom),
                    ptt_pkg::period_s_t'($urandom), clock_ms);
    end else if (pick < 70) begin
      issue_command(ptt_pkg::OP_DISABLE, ptt_pkg::id_t'($urandom),
                    ptt_pkg::period_s_t'($urandom), ptt_pkg::time_ms_t'($urandom));
    end else if (pick < 82) begin
      issue_command(ptt_pkg::OP_ADD, ptt_pkg::id_t'($urandom),
                    ptt_pkg::period_s_t'($urandom_range(65535)),
                    ptt_pkg::time_ms_t'($urandom));
    end else begin
      issue_command(ptt_pkg::OP_TICK, ptt_pkg::id_t'($urandom),
                    ptt_pkg::period_s_t'($urandom), ptt_pkg::time_ms_t'($urandom));
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: quiet tick and bare acknowledges, then two adds and a tick on unarmed slots
    issue_command(ptt_pkg::OP_TICK, 16'h0000, 16'h0000, 32'h0000_0000);
    issue_command(ptt_pkg::OP_ENABLE, 16'h0000, 16'h0000, 32'h0000_0000);
    issue_command(ptt_pkg::OP_DISABLE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    issue_command(ptt_pkg::OP_ADD, 16'h0000, 16'h0000, 32'h0000_0000);
    issue_command(ptt_pkg::OP_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    issue_command(ptt_pkg::OP_TICK, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
    // deadline sum wraps past 2^32
    issue_command(ptt_pkg::OP_ENABLE, 16'h0000, 16'h0000, 32'hFFFF_F000);
    issue_command(ptt_pkg::OP_TICK, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
    issue_command(ptt_pkg::OP_TICK, 16'h0000, 16'h0000, 32'h0000_0000);
    issue_command(ptt_pkg::OP_TICK, 16'h0000, 16'h0000, 32'd1000);

    write_min_period(8'd0);
    issue_command(ptt_pkg::OP_ADD, 16'h1234, 16'h0000, 32'h0000_0000);
    write_min_period(8'd255);
    issue_command(ptt_pkg::OP_ADD, 16'h00FF, 16'd254, 32'h0000_0000);
    issue_command(ptt_pkg::OP_ADD, 16'hA5A5, 16'hFFFF, 32'h0000_0000);
    issue_command(ptt_pkg::OP_ADD, 16'h5A5A, 16'd600, 32'h0000_0000);
    write_min_period(8'd7);
    issue_command(ptt_pkg::OP_ADD, 16'h8000, 16'd20, 32'h0000_0000);
    issue_command(ptt_pkg::OP_ADD, 16'h7FFF, 16'd1, 32'h0000_0000);
    // table full
    issue_command(ptt_pkg::OP_ADD, 16'h0001, 16'd100, 32'h0000_0000);
    // every slot due at once
    issue_command(ptt_pkg::OP_ENABLE, 16'h0000, 16'h0000, 32'h0000_0000);
    issue_command(ptt_pkg::OP_TICK, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
    issue_command(ptt_pkg::OP_TICK, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
    issue_command(ptt_pkg::OP_DISABLE, 16'h0000, 16'h0000, 32'h0000_0000);
    issue_command(ptt_pkg::OP_TICK, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
    clock_ms = 32'h1234_5678;
    issue_command(ptt_pkg::OP_ENABLE, 16'h0000, 16'h0000, clock_ms);

    sender_idle_pct = 14;
    for (int n = 0; n < WORDS_PER_PHASE; n++) random_command();
    write_min_period(8'd60);
    sender_idle_pct = 46;
    for (int n = 0; n < WORDS_PER_PHASE; n++) random_command();
    write_min_period(8'd1);
    sender_idle_pct = 0;
    for (int n = 0; n < WORDS_PER_PHASE; n++) random_command();

    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("ran %0d commands over several minimum periods, %0d result words checked",
             tracker.commands, tracker.words_checked);
    $display("%0d task firings, %0d adds refused on a full table, %0d mismatches",
             tracker.fired_words, tracker.refused_adds, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("timeout with %0d words still expected", tracker.pending_words.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
